// ===== rtl/ntb_pkg.sv =====
package ntb_pkg;

   // Field and register widths
   localparam int CENTER_BITS     = 12;
   localparam int DEPTH_BITS      = 16;
   localparam int OCX_BITS        = 22;
   localparam int FINV_BITS       = 24;
   localparam int MISS_BITS       = 8;
   localparam int SUM_BITS        = 20;
   localparam int CNT_BITS        = 4;
   localparam int RANK_BITS       = 11;
   localparam int TGT_COL_BITS    = 12;
   localparam int TGT_DEPTH_BITS  = 20;
   localparam int BEARING_BITS    = 16;
   localparam int CSR_INDEX_BITS  = 3;
   localparam int CSR_DATA_BITS   = 24;
   localparam int SAMPLE_COUNT    = 9;
   localparam int ATAN_TABLE_LEN  = 24;
   localparam int DIV_STEPS       = 24;

   // Parameter defaults
   localparam int COLUMN_BITS_DEFAULT     = 12;
   localparam int ATAN_ITERATIONS_DEFAULT = 16;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CENTER_COLUMN    = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_VALID_DEPTH_MAX  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TARGET_DEPTH_MAX = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OPTICAL_CENTER_X = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FOCAL_INVERSE    = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MISS_LIMIT       = 3'd5;

   // Register reset values
   localparam logic [CENTER_BITS-1:0] CENTER_COLUMN_RESET    = 12'd640;
   localparam logic [DEPTH_BITS-1:0]  VALID_DEPTH_MAX_RESET  = 16'd5200;
   localparam logic [DEPTH_BITS-1:0]  TARGET_DEPTH_MAX_RESET = 16'd3500;
   localparam logic [OCX_BITS-1:0]    OPTICAL_CENTER_X_RESET = 22'd654489;
   localparam logic [FINV_BITS-1:0]   FOCAL_INVERSE_RESET    = 24'd27698;
   localparam logic [MISS_BITS-1:0]   MISS_LIMIT_RESET       = 8'd20;

   // Selection and bearing limits
   localparam logic [RANK_BITS-1:0] NEAR_LIMIT  = 11'd2000;
   localparam int                   BEARING_MAX = 25736;

   // Arctangent table: floor(atan(2^-i) * 2^30)
   function automatic logic [29:0] ntb_atan(input logic [4:0] idx);
      logic [29:0] val;
      unique case (idx)
         5'd0:  val = 30'h3243F6A8;
         5'd1:  val = 30'h1DAC6705;
         5'd2:  val = 30'h0FADBAFC;
         5'd3:  val = 30'h07F56EA6;
         5'd4:  val = 30'h03FEAB76;
         5'd5:  val = 30'h01FFD55B;
         5'd6:  val = 30'h00FFFAAA;
         5'd7:  val = 30'h007FFF55;
         5'd8:  val = 30'h003FFFEA;
         5'd9:  val = 30'h001FFFFD;
         5'd10: val = 30'h000FFFFF;
         5'd11: val = 30'h0007FFFF;
         5'd12: val = 30'h0003FFFF;
         5'd13: val = 30'h0001FFFF;
         5'd14: val = 30'h0000FFFF;
         5'd15: val = 30'h00007FFF;
         5'd16: val = 30'h00003FFF;
         5'd17: val = 30'h00001FFF;
         5'd18: val = 30'h00000FFF;
         5'd19: val = 30'h000007FF;
         5'd20: val = 30'h000003FF;
         5'd21: val = 30'h000001FF;
         5'd22: val = 30'h000000FF;
         5'd23: val = 30'h0000007F;
         default: val = 30'h0;
      endcase
      return val;
   endfunction

endpackage

// ===== rtl/nearest_target_bearing_core.sv =====
// An item with a box runs 9 accumulate steps on one adder, then the keep test; an item without
// a box goes straight to the keep test. A frame-final item goes to the result if no target
// is found, else through a 24-step divider, 1 multiply and a CORDIC loop on one shift-add unit.
// One item at a time; a finished result waits in the output register while the next is taken.
// Synchronous active-high reset restores register defaults and clears frame and miss state.
module nearest_target_bearing_core
   import ntb_pkg::*;
#(
   parameter int COLUMN_BITS     = COLUMN_BITS_DEFAULT,
   parameter int ATAN_ITERATIONS = ATAN_ITERATIONS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   // configuration write channel
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data,
   // input channel
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_has_box,
   input  logic                      req_last_in_frame,
   input  logic [COLUMN_BITS-1:0]    req_box_x,
   input  logic [DEPTH_BITS-1:0]     req_depth_up_left,
   input  logic [DEPTH_BITS-1:0]     req_depth_up_mid,
   input  logic [DEPTH_BITS-1:0]     req_depth_up_right,
   input  logic [DEPTH_BITS-1:0]     req_depth_mid_left,
   input  logic [DEPTH_BITS-1:0]     req_depth_mid_mid,
   input  logic [DEPTH_BITS-1:0]     req_depth_mid_right,
   input  logic [DEPTH_BITS-1:0]     req_depth_down_left,
   input  logic [DEPTH_BITS-1:0]     req_depth_down_mid,
   input  logic [DEPTH_BITS-1:0]     req_depth_down_right,
   // result channel
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_target_found,
   output logic [TGT_COL_BITS-1:0]   rsp_target_column,
   output logic [TGT_DEPTH_BITS-1:0] rsp_target_depth,
   output logic signed [BEARING_BITS-1:0] rsp_bearing,
   output logic [MISS_BITS-1:0]      rsp_missed_frames,
   output logic                      rsp_target_lost
);

   // Derived widths
   localparam int DIST_BITS = (COLUMN_BITS > CENTER_BITS) ? COLUMN_BITS : CENTER_BITS;
   localparam int DW        = ((COLUMN_BITS + 10 > OCX_BITS) ? COLUMN_BITS + 10 : OCX_BITS) + 1;
   localparam int PW        = DW + FINV_BITS + 1;
   localparam int CW        = PW + 2;
   localparam int ZW        = 33;
   localparam int ITERS     = (ATAN_ITERATIONS < ATAN_TABLE_LEN) ? ATAN_ITERATIONS
                                                                   : ATAN_TABLE_LEN;

   // Sequencer states
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_ACC  = 3'd1;
   localparam logic [2:0] ST_KEEP = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_MUL  = 3'd4;
   localparam logic [2:0] ST_CORD = 3'd5;
   localparam logic [2:0] ST_OUT  = 3'd6;

   logic [2:0] state_ff, state_in;
   logic [4:0] iter_ff, iter_in;

   // Configuration registers
   logic [CENTER_BITS-1:0] center_column_ff;
   logic [DEPTH_BITS-1:0]  valid_depth_max_ff;
   logic [DEPTH_BITS-1:0]  target_depth_max_ff;
   logic [OCX_BITS-1:0]    optical_center_x_ff;
   logic [FINV_BITS-1:0]   focal_inverse_ff;
   logic [MISS_BITS-1:0]   miss_limit_ff;

   // Captured item
   logic                   has_ff;
   logic                   last_ff;
   logic [COLUMN_BITS-1:0] bx_ff;
   logic [DEPTH_BITS-1:0]  samp_ff [SAMPLE_COUNT];

   // Item accumulation
   logic [SUM_BITS-1:0]    sum_ff;
   logic [CNT_BITS-1:0]    cnt_ff;

   // Frame tracking state
   logic [RANK_BITS-1:0]   best_distance_ff;
   logic [COLUMN_BITS-1:0] best_column_ff;
   logic [SUM_BITS-1:0]    best_depth_sum_ff;
   logic [CNT_BITS-1:0]    best_valid_count_ff;
   logic                   found_in_frame_ff;
   logic [MISS_BITS-1:0]   miss_counter_ff;

   // Divider and CORDIC working registers
   logic [DIV_STEPS-1:0]   quot_ff;
   logic [CNT_BITS-1:0]    rem_ff;
   logic signed [CW-1:0]   x_ff, y_ff;
   logic signed [ZW-1:0]   z_ff;

   // Output register
   logic                      rsp_valid_ff;
   logic                      rsp_found_ff;
   logic [TGT_COL_BITS-1:0]   rsp_column_ff;
   logic [TGT_DEPTH_BITS-1:0] rsp_depth_ff;
   logic [BEARING_BITS-1:0]   rsp_bearing_ff;
   logic [MISS_BITS-1:0]      rsp_missed_ff;
   logic                      rsp_lost_ff;

   logic req_xfer, csr_xfer, rsp_load, frame_hit;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign req_xfer  = req_valid && req_ready;
   assign csr_xfer  = csr_valid && csr_ready;
   assign rsp_load  = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready);
   assign frame_hit = found_in_frame_ff && (best_valid_count_ff != '0);

   // Accumulate one sample per step
   logic [DEPTH_BITS-1:0] acc_samp;
   logic                  acc_ok;
   assign acc_samp = samp_ff[iter_ff[3:0]];
   assign acc_ok   = (acc_samp != '0) && (acc_samp <= valid_depth_max_ff);

   // Keep test and rank
   logic [SUM_BITS-1:0]  keep_limit;
   logic                 keep;
   logic [DIST_BITS-1:0] bx_ext, cc_ext, col_gap;
   logic [RANK_BITS-1:0] rank;
   logic                 better;
   assign keep_limit = SUM_BITS'(target_depth_max_ff) * SUM_BITS'(cnt_ff);
   assign keep       = has_ff && (cnt_ff != '0) && (sum_ff <= keep_limit);
   assign bx_ext     = DIST_BITS'(bx_ff);
   assign cc_ext     = DIST_BITS'(center_column_ff);
   assign col_gap    = (bx_ext >= cc_ext) ? (bx_ext - cc_ext) : (cc_ext - bx_ext);
   assign rank       = (col_gap < DIST_BITS'(NEAR_LIMIT)) ? RANK_BITS'(col_gap) : NEAR_LIMIT;
   assign better     = !found_in_frame_ff || (rank < best_distance_ff) ||
                       ((rank == best_distance_ff) && (bx_ff < best_column_ff));

   // Restoring divider step
   logic [CNT_BITS:0]      div_shift;
   logic                   div_take;
   logic [DIV_STEPS-1:0]   div_init;
   assign div_shift = {rem_ff, quot_ff[DIV_STEPS-1]};
   assign div_take  = (div_shift >= {1'b0, best_valid_count_ff});
   assign div_init  = {best_depth_sum_ff, 4'b0000} +
                      DIV_STEPS'(best_valid_count_ff >> 1);

   // Bearing numerator
   logic signed [DW-1:0] diff;
   logic signed [PW-1:0] prod;
   assign diff = $signed({1'b0, best_column_ff, 10'b0}) - $signed(DW'(optical_center_x_ff));
   assign prod = diff * $signed({1'b0, focal_inverse_ff});

   // CORDIC shift-add step
   logic signed [CW-1:0] xs, ys;
   logic signed [ZW-1:0] ang;
   assign xs  = x_ff >>> iter_ff;
   assign ys  = y_ff >>> iter_ff;
   assign ang = $signed(ZW'(ntb_atan(iter_ff)));

   // Round and clamp the angle
   logic signed [ZW-1:0]           z_rnd;
   logic signed [BEARING_BITS-1:0] bearing_val;
   assign z_rnd = (z_ff + $signed(ZW'(32768))) >>> 16;
   always_comb begin
      if (z_rnd > $signed(ZW'(BEARING_MAX))) begin
         bearing_val = BEARING_BITS'(BEARING_MAX);
      end else if (z_rnd < -$signed(ZW'(BEARING_MAX))) begin
         bearing_val = -BEARING_BITS'(BEARING_MAX);
      end else begin
         bearing_val = z_rnd[BEARING_BITS-1:0];
      end
   end

   // Miss count for a frame without target
   logic [MISS_BITS-1:0] miss_next;
   assign miss_next = (miss_counter_ff == '1) ? miss_counter_ff : miss_counter_ff + 1'b1;

   // Next state
   always_comb begin
      state_in = state_ff;
      iter_in  = iter_ff;
      unique case (state_ff)
         ST_IDLE: begin
            iter_in = '0;
            if (req_xfer) state_in = req_has_box ? ST_ACC : ST_KEEP;
         end
         ST_ACC: begin
            iter_in = iter_ff + 1'b1;
            if (iter_ff == 5'(SAMPLE_COUNT - 1)) state_in = ST_KEEP;
         end
         ST_KEEP: begin
            iter_in = '0;
            state_in = last_ff ? ST_DIV : ST_IDLE;
         end
         ST_DIV: begin
            iter_in = iter_ff + 1'b1;
            if (!frame_hit) begin
               state_in = ST_OUT;
            end else if (iter_ff == 5'(DIV_STEPS - 1)) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            iter_in  = '0;
            state_in = ST_CORD;
         end
         ST_CORD: begin
            iter_in = iter_ff + 1'b1;
            if (iter_ff == 5'(ITERS - 1)) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control, configuration and tracking state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff            <= ST_IDLE;
         iter_ff             <= '0;
         center_column_ff    <= CENTER_COLUMN_RESET;
         valid_depth_max_ff  <= VALID_DEPTH_MAX_RESET;
         target_depth_max_ff <= TARGET_DEPTH_MAX_RESET;
         optical_center_x_ff <= OPTICAL_CENTER_X_RESET;
         focal_inverse_ff    <= FOCAL_INVERSE_RESET;
         miss_limit_ff       <= MISS_LIMIT_RESET;
         best_distance_ff    <= NEAR_LIMIT;
         best_column_ff      <= '0;
         best_depth_sum_ff   <= '0;
         best_valid_count_ff <= '0;
         found_in_frame_ff   <= 1'b0;
         miss_counter_ff     <= '0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         state_ff <= state_in;
         iter_ff  <= iter_in;
         // write configuration
         if (csr_xfer) begin
            unique case (csr_index)
               CSR_CENTER_COLUMN:    center_column_ff    <= csr_data[CENTER_BITS-1:0];
               CSR_VALID_DEPTH_MAX:  valid_depth_max_ff  <= csr_data[DEPTH_BITS-1:0];
               CSR_TARGET_DEPTH_MAX: target_depth_max_ff <= csr_data[DEPTH_BITS-1:0];
               CSR_OPTICAL_CENTER_X: optical_center_x_ff <= csr_data[OCX_BITS-1:0];
               CSR_FOCAL_INVERSE:    focal_inverse_ff    <= csr_data[FINV_BITS-1:0];
               CSR_MISS_LIMIT:       miss_limit_ff       <= csr_data[MISS_BITS-1:0];
               default: ;
            endcase
         end
         // track the nearest kept box
         if ((state_ff == ST_KEEP) && keep && better) begin
            best_distance_ff    <= rank;
            best_column_ff      <= bx_ff;
            best_depth_sum_ff   <= sum_ff;
            best_valid_count_ff <= cnt_ff;
            found_in_frame_ff   <= 1'b1;
         end
         // close the frame
         if (rsp_load) begin
            best_distance_ff    <= NEAR_LIMIT;
            best_column_ff      <= '0;
            best_depth_sum_ff   <= '0;
            best_valid_count_ff <= '0;
            found_in_frame_ff   <= 1'b0;
            miss_counter_ff     <= frame_hit ? '0 : miss_next;
         end
         // hold the result until transfer
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         has_ff     <= req_has_box;
         last_ff    <= req_last_in_frame;
         bx_ff      <= req_box_x;
         samp_ff[0] <= req_depth_up_left;
         samp_ff[1] <= req_depth_up_mid;
         samp_ff[2] <= req_depth_up_right;
         samp_ff[3] <= req_depth_mid_left;
         samp_ff[4] <= req_depth_mid_mid;
         samp_ff[5] <= req_depth_mid_right;
         samp_ff[6] <= req_depth_down_left;
         samp_ff[7] <= req_depth_down_mid;
         samp_ff[8] <= req_depth_down_right;
         sum_ff     <= '0;
         cnt_ff     <= '0;
      end
      // add valid sample
      if ((state_ff == ST_ACC) && acc_ok) begin
         sum_ff <= sum_ff + SUM_BITS'(acc_samp);
         cnt_ff <= cnt_ff + 1'b1;
      end
      // clear the divider
      if (state_ff == ST_KEEP) begin
         quot_ff <= '0;
         rem_ff  <= '0;
      end
      // divide one bit per step
      if (state_ff == ST_DIV) begin
         if (iter_ff == '0) begin
            quot_ff <= {div_init[DIV_STEPS-2:0],
                        div_init[DIV_STEPS-1] && (best_valid_count_ff == 4'd1)};
            rem_ff  <= (div_init[DIV_STEPS-1] && (best_valid_count_ff == 4'd1)) ? 4'd0
                       : CNT_BITS'(div_init[DIV_STEPS-1]);
         end else begin
            quot_ff <= {quot_ff[DIV_STEPS-2:0], div_take};
            rem_ff  <= div_take ? CNT_BITS'(div_shift - {1'b0, best_valid_count_ff})
                                : CNT_BITS'(div_shift);
         end
      end
      // seed the CORDIC
      if (state_ff == ST_MUL) begin
         x_ff <= $signed({{(CW - 35){1'b0}}, 1'b1, 34'b0});
         y_ff <= CW'(prod);
         z_ff <= '0;
      end
      // rotate toward the axis
      if (state_ff == ST_CORD) begin
         if (!y_ff[CW-1]) begin
            x_ff <= x_ff + ys;
            y_ff <= y_ff - xs;
            z_ff <= z_ff + ang;
         end else begin
            x_ff <= x_ff - ys;
            y_ff <= y_ff + xs;
            z_ff <= z_ff - ang;
         end
      end
      // load the result
      if (rsp_load) begin
         rsp_found_ff   <= frame_hit;
         rsp_column_ff  <= frame_hit ? TGT_COL_BITS'(best_column_ff) : '0;
         rsp_depth_ff   <= frame_hit ? quot_ff[TGT_DEPTH_BITS-1:0] : '0;
         rsp_bearing_ff <= frame_hit ? bearing_val : '0;
         rsp_missed_ff  <= frame_hit ? '0 : miss_next;
         rsp_lost_ff    <= frame_hit ? 1'b0 : (miss_next >= miss_limit_ff);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_target_found  = rsp_found_ff;
   assign rsp_target_column = rsp_column_ff;
   assign rsp_target_depth  = rsp_depth_ff;
   assign rsp_bearing       = rsp_bearing_ff;
   assign rsp_missed_frames = rsp_missed_ff;
   assign rsp_target_lost   = rsp_lost_ff;

   // Checks
   a_miss_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_found_ff |->
         (rsp_column_ff == '0) && (rsp_depth_ff == '0) && (rsp_bearing_ff == '0))
      else $error("miss result carries nonzero target fields");

   a_hit_no_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_found_ff |-> (rsp_missed_ff == '0) && !rsp_lost_ff)
      else $error("hit result reports missed frames");

   a_bearing_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($signed(rsp_bearing_ff) <= $signed(16'sd25736)) &&
                       ($signed(rsp_bearing_ff) >= -$signed(16'sd25736)))
      else $error("bearing outside clamp range");

   a_frame_cleared: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> !found_in_frame_ff && (best_distance_ff == NEAR_LIMIT))
      else $error("frame state not cleared after result");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      best_valid_count_ff <= 4'd9)
      else $error("tracked valid count exceeds window size");

endmodule

// ===== tb/tb.sv =====
module tb
   import ntb_pkg::*;
();

   localparam int     HALF_PERIOD       = 2;
   localparam int     RESET_CYCLES      = 7;
   localparam int     RANDOM_ITEMS      = 140;
   localparam int     NO_TARGET_ITEMS   = 60;
   localparam int     SATURATE_FRAMES   = 260;
   localparam int     QUIET_CYCLES      = 60;
   localparam int     DRAIN_LIMIT       = 20000;
   localparam longint TIMEOUT_CYCLES    = 1000000;
   localparam int     REPORT_LIMIT      = 10;
   localparam int     NEAR_RANK         = NEAR_LIMIT;
   localparam int     MISS_CEILING      = (1 << MISS_BITS) - 1;
   localparam int     DEPTH_TOP         = (1 << DEPTH_BITS) - 1;
   localparam int     COLUMN_TOP        = (1 << COLUMN_BITS_DEFAULT) - 1;
   // indexes with no register behind them
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_HI = 3'd7;

   typedef struct packed {
      logic                                    has_box;
      logic                                    last_in_frame;
      logic [COLUMN_BITS_DEFAULT-1:0]          box_x;
      logic [SAMPLE_COUNT-1:0][DEPTH_BITS-1:0] samples;
   } detection_type;

   typedef struct packed {
      logic                           found;
      logic [TGT_COL_BITS-1:0]        column;
      logic [TGT_DEPTH_BITS-1:0]      depth;
      logic signed [BEARING_BITS-1:0] bearing;
      logic [MISS_BITS-1:0]           missed;
      logic                           lost;
   } track_report_type;

   typedef struct packed {
      logic [CENTER_BITS-1:0] center;
      logic [DEPTH_BITS-1:0]  valid_max;
      logic [DEPTH_BITS-1:0]  accept_max;
      logic [OCX_BITS-1:0]    ocx;
      logic [FINV_BITS-1:0]   finv;
      logic [MISS_BITS-1:0]   miss_limit;
   } tuning_type;

   // Tracks the nearest kept box per frame and holds the frame reports still owed
   class tracker_scoreboard_type;
      int     center, valid_max, accept_max, miss_limit;
      longint ocx, finv;
      int     best_rank, best_col, best_sum, best_cnt, misses;
      bit     frame_hit;
      longint atan_steps[ATAN_TABLE_LEN];
      track_report_type expected_reports[$];
      int     failures, items, boxed, reports, hits, losses;

      function new();
         atan_steps = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
                        64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
                        64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
                        64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
                        64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
                        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};
         center     = CENTER_COLUMN_RESET;
         valid_max  = VALID_DEPTH_MAX_RESET;
         accept_max = TARGET_DEPTH_MAX_RESET;
         ocx        = OPTICAL_CENTER_X_RESET;
         finv       = FOCAL_INVERSE_RESET;
         miss_limit = MISS_LIMIT_RESET;
         misses     = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         best_rank = NEAR_RANK;
         best_col  = 0;
         best_sum  = 0;
         best_cnt  = 0;
         frame_hit = 1'b0;
      endfunction

      function void set_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] val);
         case (idx)
            CSR_CENTER_COLUMN:    center     = val[CENTER_BITS-1:0];
            CSR_VALID_DEPTH_MAX:  valid_max  = val[DEPTH_BITS-1:0];
            CSR_TARGET_DEPTH_MAX: accept_max = val[DEPTH_BITS-1:0];
            CSR_OPTICAL_CENTER_X: ocx        = val[OCX_BITS-1:0];
            CSR_FOCAL_INVERSE:    finv       = val[FINV_BITS-1:0];
            CSR_MISS_LIMIT:       miss_limit = val[MISS_BITS-1:0];
            default: ;
         endcase
      endfunction

      // CORDIC vectoring from (2^34, offset * finv), angle rounded to Q2.14 and clamped
      function logic signed [BEARING_BITS-1:0] steer_angle(int col);
         longint x, y, z, xs, ys, col_q;
         int     i;
         col_q = col;
         x = longint'(1) << 34;
         y = (col_q * 1024 - ocx) * finv;
         z = 0;
         for (i = 0; i < ATAN_ITERATIONS_DEFAULT; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
               x += ys;
               y -= xs;
               z += atan_steps[i];
            end else begin
               x -= ys;
               y += xs;
               z -= atan_steps[i];
            end
         end
         z = (z + (longint'(1) << 15)) >>> 16;
         if (z > BEARING_MAX) z = BEARING_MAX;
         if (z < -BEARING_MAX) z = -BEARING_MAX;
         return z[BEARING_BITS-1:0];
      endfunction

      // Fold one accepted detection into the frame; owe a report on the frame's last item
      function void note_item(detection_type d);
         int sum, cnt, rank, s, k, x;
         track_report_type rep;
         items++;
         if (d.has_box) begin
            boxed++;
            sum = 0;
            cnt = 0;
            for (k = 0; k < SAMPLE_COUNT; k++) begin
               s = d.samples[k];
               if (s != 0 && s <= valid_max) begin
                  sum += s;
                  cnt++;
               end
            end
            if (cnt != 0 && sum <= accept_max * cnt) begin
               x = d.box_x;
               rank = (x >= center) ? x - center : center - x;
               if (rank > NEAR_RANK) rank = NEAR_RANK;
               if (!frame_hit || rank < best_rank || (rank == best_rank && x < best_col)) begin
                  best_rank = rank;
                  best_col  = x;
                  best_sum  = sum;
                  best_cnt  = cnt;
                  frame_hit = 1'b1;
               end
            end
         end
         if (!d.last_in_frame) return;

         rep = '0;
         if (frame_hit && best_cnt != 0) begin
            misses      = 0;
            rep.found   = 1'b1;
            rep.column  = TGT_COL_BITS'(best_col);
            rep.depth   = TGT_DEPTH_BITS'((best_sum * 16 + best_cnt / 2) / best_cnt);
            rep.bearing = steer_angle(best_col);
            hits++;
         end else begin
            if (misses < MISS_CEILING) misses++;
            rep.missed = MISS_BITS'(misses);
            rep.lost   = (misses >= miss_limit);
            if (rep.lost) losses++;
         end
         reports++;
         expected_reports = {expected_reports, rep};
         clear_frame();
      endfunction

      function string show(track_report_type r);
         return $sformatf("found=%0d column=%0d depth=%0d bearing=%0d missed=%0d lost=%0d",
                          r.found, r.column, r.depth, $signed(r.bearing), r.missed, r.lost);
      endfunction

      function void flag(string msg);
         failures++;
         if (failures <= REPORT_LIMIT) $display("MISMATCH %s", msg);
      endfunction

      // Compare one accepted result with the oldest owed report
      function void check_report(track_report_type got);
         track_report_type want;
         if (expected_reports.size() == 0) begin
            flag($sformatf("result with none owed: %s", show(got)));
            return;
         end
         want = expected_reports.pop_front();
         if (got.found !== want.found || got.column !== want.column ||
             got.depth !== want.depth || got.bearing !== want.bearing ||
             got.missed !== want.missed || got.lost !== want.lost)
            flag($sformatf("expected %s, got %s", show(want), show(got)));
      endfunction

      function void close_out();
         if (expected_reports.size() != 0) begin
            failures += expected_reports.size() - 1;
            flag($sformatf("%0d owed results never came, oldest %s",
                           expected_reports.size(), show(expected_reports[0])));
         end
      endfunction
   endclass

   logic                      clock     = 1'b0;
   logic                      reset     = 1'b1;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data  = '0;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   detection_type             req_item  = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic                      rsp_target_found;
   logic [TGT_COL_BITS-1:0]   rsp_target_column;
   logic [TGT_DEPTH_BITS-1:0] rsp_target_depth;
   logic signed [BEARING_BITS-1:0] rsp_bearing;
   logic [MISS_BITS-1:0]      rsp_missed_frames;
   logic                      rsp_target_lost;

   tracker_scoreboard_type sb;
   int     send_gap_pct  = 0;
   int     stall_pct     = 0;
   int     settings_run  = 0;
   longint cycle_count   = 0;

   nearest_target_bearing_core DUT (
      .clock                (clock),
      .reset                (reset),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_has_box          (req_item.has_box),
      .req_last_in_frame    (req_item.last_in_frame),
      .req_box_x            (req_item.box_x),
      .req_depth_up_left    (req_item.samples[0]),
      .req_depth_up_mid     (req_item.samples[1]),
      .req_depth_up_right   (req_item.samples[2]),
      .req_depth_mid_left   (req_item.samples[3]),
      .req_depth_mid_mid    (req_item.samples[4]),
      .req_depth_mid_right  (req_item.samples[5]),
      .req_depth_down_left  (req_item.samples[6]),
      .req_depth_down_mid   (req_item.samples[7]),
      .req_depth_down_right (req_item.samples[8]),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_target_found     (rsp_target_found),
      .rsp_target_column    (rsp_target_column),
      .rsp_target_depth     (rsp_target_depth),
      .rsp_bearing          (rsp_bearing),
      .rsp_missed_frames    (rsp_missed_frames),
      .rsp_target_lost      (rsp_target_lost)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // Stall the result channel at random
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // Watch both channels: check results, then note the accepted detection
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            sb.check_report({rsp_target_found, rsp_target_column, rsp_target_depth,
                             rsp_bearing, rsp_missed_frames, rsp_target_lost});
         if (req_valid && req_ready) sb.note_item(req_item);
      end
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == TIMEOUT_CYCLES) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Hold one detection on the input channel until its transfer; valid stays up afterwards
   task automatic send_item(input detection_type d);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_item  <= d;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Write one register; valid stays up for a following write
   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_reg(idx, val);
      @(negedge clock);
   endtask

   task automatic program_regs(input tuning_type t);
      write_reg(CSR_CENTER_COLUMN,    CSR_DATA_BITS'(t.center));
      write_reg(CSR_VALID_DEPTH_MAX,  CSR_DATA_BITS'(t.valid_max));
      write_reg(CSR_TARGET_DEPTH_MAX, CSR_DATA_BITS'(t.accept_max));
      write_reg(CSR_OPTICAL_CENTER_X, CSR_DATA_BITS'(t.ocx));
      write_reg(CSR_FOCAL_INVERSE,    CSR_DATA_BITS'(t.finv));
      write_reg(CSR_MISS_LIMIT,       CSR_DATA_BITS'(t.miss_limit));
      write_reg(CSR_SPARE_LO, CSR_DATA_BITS'($urandom));
      write_reg(CSR_SPARE_HI, CSR_DATA_BITS'($urandom));
      csr_valid <= 1'b0;
      settings_run++;
   endtask

   // Drop valid and wait for every owed report, then let the block go quiet
   task automatic settle();
      int waited;
      req_valid <= 1'b0;
      waited = 0;
      while (sb.expected_reports.size() != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (QUIET_CYCLES) @(negedge clock);
   endtask

   function automatic detection_type make_item(bit has, bit last, int x, int s0, int s1,
                                               int rest);
      detection_type d;
      int k;
      d.has_box       = has;
      d.last_in_frame = last;
      d.box_x         = COLUMN_BITS_DEFAULT'(x);
      for (k = 0; k < SAMPLE_COUNT; k++) d.samples[k] = DEPTH_BITS'(rest);
      d.samples[0] = DEPTH_BITS'(s0);
      d.samples[1] = DEPTH_BITS'(s1);
      return d;
   endfunction

   // Mostly valid samples around the accepted range, with zeros and too-far ones mixed in
   function automatic logic [DEPTH_BITS-1:0] pick_sample(int valid_max, int accept_max);
      int roll, top;
      roll = $urandom_range(99);
      top = accept_max + accept_max / 4 + 1;
      if (top > valid_max) top = valid_max;
      if (roll < 15) return '0;
      if (roll < 25)
         return (valid_max < DEPTH_TOP) ? DEPTH_BITS'($urandom_range(DEPTH_TOP, valid_max + 1))
                                        : DEPTH_BITS'(DEPTH_TOP);
      if (roll < 35) return DEPTH_BITS'($urandom);
      return (top < 1) ? DEPTH_BITS'(1) : DEPTH_BITS'($urandom_range(top, 1));
   endfunction

   // One frame of 1..5 items; columns cluster near the center and repeat or mirror for ties
   task automatic send_random_frame(output int sent);
      detection_type d;
      int len, i, k, x, prev_x, roll;
      len = $urandom_range(5, 1);
      prev_x = sb.center;
      for (i = 0; i < len; i++) begin
         if ($urandom_range(99) < 8) begin
            d.has_box       = 1'($urandom_range(1));
            d.last_in_frame = 1'($urandom_range(1));
            d.box_x         = COLUMN_BITS_DEFAULT'($urandom);
            for (k = 0; k < SAMPLE_COUNT; k++) d.samples[k] = DEPTH_BITS'($urandom);
         end else begin
            roll = $urandom_range(99);
            if (roll < 45)      x = sb.center - 40 + int'($urandom_range(80));
            else if (roll < 65) x = sb.center - 2100 + int'($urandom_range(4200));
            else if (roll < 73) x = prev_x;
            else if (roll < 80) x = 2 * sb.center - prev_x;
            else                x = $urandom_range(COLUMN_TOP);
            if (x < 0) x = 0;
            if (x > COLUMN_TOP) x = COLUMN_TOP;
            prev_x = x;
            d.has_box       = ($urandom_range(9) != 0);
            d.last_in_frame = (i == len - 1);
            d.box_x         = COLUMN_BITS_DEFAULT'(x);
            for (k = 0; k < SAMPLE_COUNT; k++)
               d.samples[k] = pick_sample(sb.valid_max, sb.accept_max);
         end
         send_item(d);
      end
      sent = len;
   endtask

   task automatic run_random(input int count);
      int done, n;
      done = 0;
      while (done < count) begin
         send_random_frame(n);
         done += n;
      end
   endtask

   task automatic run_directed();
      // empty frame, then boxes with no usable sample: all misses
      send_item(make_item(0, 1, 640, 0, 0, 0));
      send_item(make_item(1, 1, 640, 0, 0, 0));
      send_item(make_item(1, 1, COLUMN_TOP, DEPTH_TOP, DEPTH_TOP, DEPTH_TOP));
      // samples exactly at the valid limit, average above the accepted range
      send_item(make_item(1, 1, 0, 5200, 5200, 5200));
      // average exactly at the accepted limit is kept
      send_item(make_item(1, 1, 100, 3500, 0, 0));
      // one over the limit dropped, far right box remains, empty item closes the frame
      send_item(make_item(1, 0, 200, 3501, 5201, 5201));
      send_item(make_item(1, 0, COLUMN_TOP, 1, 1, 1));
      send_item(make_item(0, 1, 4000, 9999, 9999, 9999));
      // equal distance on both sides: smaller column wins, a repeat keeps the first
      send_item(make_item(1, 0, 680, 1000, 1000, 1000));
      send_item(make_item(1, 0, 600, 2000, 2000, 2000));
      send_item(make_item(1, 1, 600, 3000, 0, 0));
      // both beyond the distance cap: smallest column wins
      send_item(make_item(1, 0, 3000, 1500, 1500, 1500));
      send_item(make_item(1, 1, 2700, 1200, 1200, 1200));
      // rounding of the average depth
      send_item(make_item(1, 1, 640, 2, 1, 0));
      send_item(make_item(1, 1, 641, 2, 1, 1));
      // a closer box arriving later replaces the earlier one
      send_item(make_item(1, 0, 1200, 800, 800, 800));
      send_item(make_item(1, 1, 639, DEPTH_TOP, 900, 0));
   endtask

   initial begin
      tuning_type t;
      int i;
      sb = new();

      // sender rarely idle, receiver often stalled
      send_gap_pct = 6;
      stall_pct    = 57;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      run_directed();
      run_random(RANDOM_ITEMS);
      settle();

      // extremes: widest ranges, bearing driven to its clamp, lost flag up on every miss
      t = '{center: '0, valid_max: '1, accept_max: '1, ocx: '0, finv: '1, miss_limit: '0};
      program_regs(t);
      run_random(RANDOM_ITEMS);
      settle();

      // swap idling: sender often idle, receiver rarely stalled
      send_gap_pct = 57;
      stall_pct    = 6;
      t = '{center: '1, valid_max: 16'd1000, accept_max: 16'd600, ocx: '1, finv: '0,
            miss_limit: '1};
      program_regs(t);
      // run the miss counter into saturation
      for (i = 0; i < SATURATE_FRAMES; i++)
         send_item(make_item(0, 1, $urandom, $urandom, $urandom, $urandom));
      run_random(RANDOM_ITEMS);
      settle();

      // no sample can be valid: every frame misses
      t = '{center: 12'd2047, valid_max: '0, accept_max: '0, ocx: 22'd2097152, finv: 24'd1,
            miss_limit: 8'd1};
      program_regs(t);
      run_random(NO_TARGET_ITEMS);
      settle();

      // no idling from here on
      send_gap_pct = 0;
      stall_pct    = 0;
      t.center     = CENTER_BITS'($urandom);
      t.valid_max  = DEPTH_BITS'($urandom);
      t.accept_max = DEPTH_BITS'($urandom);
      t.ocx        = OCX_BITS'($urandom);
      t.finv       = FINV_BITS'($urandom_range((1 << FINV_BITS) - 1, 1));
      t.miss_limit = MISS_BITS'($urandom);
      program_regs(t);
      run_random(RANDOM_ITEMS);
      settle();

      t = '{center: CENTER_COLUMN_RESET, valid_max: VALID_DEPTH_MAX_RESET,
            accept_max: TARGET_DEPTH_MAX_RESET, ocx: OPTICAL_CENTER_X_RESET,
            finv: FOCAL_INVERSE_RESET, miss_limit: 8'd3};
      program_regs(t);
      run_random(RANDOM_ITEMS);
      settle();

      sb.close_out();
      $display("covered %0d detections (%0d with a box) under %0d register settings",
               sb.items, sb.boxed, settings_run + 1);
      $display("%0d frame results: %0d with a target, %0d flagged lost; %0d failures",
               sb.reports, sb.hits, sb.losses, sb.failures);
      if (sb.failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
